// ----- hw/rtl/lmc_pkg.sv -----
package lmc_pkg;

  // Character code width and the number of distinct codes tracked.
  localparam int CHAR_W    = 8;
  localparam int NUM_CHARS = 1 << CHAR_W;

  // Width of the running count of negative balances (holds 0..NUM_CHARS).
  localparam int NEG_CNT_W = CHAR_W + 1;

  // Default width of one signed balance entry.
  localparam int BALANCE_WIDTH_DEF = 16;

  // Request function codes.
  localparam logic [1:0] FUNC_SOURCE = 2'd0;
  localparam logic [1:0] FUNC_TARGET = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rd_en;   // capture a byte request and read its balance
    logic wr_en;   // update the captured balance and the negative count
    logic finish;  // report the result and start a fresh query
  } cmd_t;

  // ASCII upper-case letters map to lower case; every other byte is kept.
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] c;
    c = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      c = b + 8'h20;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/letter_multiset_containment_core.sv -----
// Letter multiset containment: tells whether a target name can be spelled from the
// letters of a source name, ignoring ASCII case. Send each source byte as a request
// with func FUNC_SOURCE and each target byte with func FUNC_TARGET, in any mix, then
// a request with func FUNC_FINISH; the finish returns one result, out_possible = 1
// when every target character is covered (also when no target byte was sent), and
// starts a new query at once. Other function codes are dropped without effect.
// A byte request is a read-modify-write; the balance memory read is registered, so
// the update of one character occupies the read cycle and the write cycle. A finish
// empties the store by clearing its per-entry valid bits together, so no clearing
// walk follows it. Balances saturate at the limits
// of a signed BALANCE_WIDTH value. A waiting result does not hold up byte requests;
// only a following finish waits until the earlier result has been taken.
module letter_multiset_containment_core #(
  parameter int BALANCE_WIDTH = lmc_pkg::BALANCE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Request channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_func,
  input  logic [lmc_pkg::CHAR_W-1:0] in_char_byte,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_possible
);

  lmc_pkg::cmd_t cmd;

  // The controller sequences each request and owns the result handshake.
  lmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the balance memory, the negative count and the result.
  lmc_datapath #(
    .BALANCE_WIDTH (BALANCE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (in_func),
    .in_char_byte (in_char_byte),
    .out_possible (out_possible)
  );

endmodule

// ----- hw/rtl/lmc_ctrl.sv -----
module lmc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_func,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output lmc_pkg::cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RMW
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   is_byte;
  logic   is_finish;

  always_comb begin
    is_byte   = (in_func inside {lmc_pkg::FUNC_SOURCE, lmc_pkg::FUNC_TARGET});
    is_finish = (in_func == lmc_pkg::FUNC_FINISH);
    // A finish must wait while an earlier result is still held.
    in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall && is_finish);
    accept    = in_valid && !in_stall;

    cmd.rd_en  = accept && is_byte;
    cmd.finish = accept && is_finish;
    cmd.wr_en  = (state_r == ST_RMW);

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.rd_en) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/lmc_datapath.sv -----
module lmc_datapath #(
  parameter int BALANCE_WIDTH = lmc_pkg::BALANCE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lmc_pkg::cmd_t               cmd,
  input  logic [1:0]                  in_func,
  input  logic [lmc_pkg::CHAR_W-1:0]  in_char_byte,
  output logic                        out_possible
);

  localparam logic [BALANCE_WIDTH-1:0] BAL_MAX = {1'b0, {(BALANCE_WIDTH-1){1'b1}}};
  localparam logic [BALANCE_WIDTH-1:0] BAL_MIN = {1'b1, {(BALANCE_WIDTH-1){1'b0}}};

  logic [BALANCE_WIDTH-1:0]     bal_mem [lmc_pkg::NUM_CHARS];
  logic [lmc_pkg::NUM_CHARS-1:0] vld_r;
  logic [lmc_pkg::NEG_CNT_W-1:0] neg_cnt_r;
  logic [lmc_pkg::NEG_CNT_W-1:0] neg_cnt_nxt;
  logic [lmc_pkg::CHAR_W-1:0]   addr_r;
  logic [lmc_pkg::CHAR_W-1:0]   addr_fold;
  logic                         is_target_r;
  logic [BALANCE_WIDTH-1:0]     rd_data_r;
  logic                         rd_vld_r;
  logic [BALANCE_WIDTH-1:0]     old_bal;
  logic [BALANCE_WIDTH-1:0]     new_bal;
  logic                         possible_r;

  assign addr_fold = lmc_pkg::fold_case(in_char_byte);

  // Entries not written since the last finish read as zero.
  always_comb begin
    old_bal = rd_vld_r ? rd_data_r : '0;
    if (is_target_r) begin
      new_bal = (old_bal == BAL_MIN) ? BAL_MIN : old_bal - 1'b1;
    end else begin
      new_bal = (old_bal == BAL_MAX) ? BAL_MAX : old_bal + 1'b1;
    end

    neg_cnt_nxt = neg_cnt_r;
    if (old_bal[BALANCE_WIDTH-1] && !new_bal[BALANCE_WIDTH-1]) begin
      neg_cnt_nxt = neg_cnt_r - 1'b1;
    end else if (!old_bal[BALANCE_WIDTH-1] && new_bal[BALANCE_WIDTH-1]) begin
      neg_cnt_nxt = neg_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= bal_mem[addr_fold];
    end
    if (cmd.wr_en) begin
      bal_mem[addr_r] <= new_bal;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      addr_r      <= addr_fold;
      is_target_r <= (in_func == lmc_pkg::FUNC_TARGET);
      rd_vld_r    <= vld_r[addr_fold];
    end
    if (cmd.finish) begin
      possible_r <= (neg_cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      neg_cnt_r <= '0;
    end else if (cmd.finish) begin
      vld_r     <= '0;
      neg_cnt_r <= '0;
    end else if (cmd.wr_en) begin
      vld_r[addr_r] <= 1'b1;
      neg_cnt_r     <= neg_cnt_nxt;
    end
  end

  assign out_possible = possible_r;

endmodule
